### rtl/ghs_pkg.sv
package ghs_pkg;

  // Map geometry
  localparam int MAP_SIDE    = 64;
  localparam int COORD_W     = $clog2(MAP_SIDE);
  localparam int CNT_W       = $clog2(MAP_SIDE + 1);
  localparam int ADDR_W      = 2 * COORD_W;
  localparam int MAP_CELLS   = 1 << ADDR_W;

  // Field and register widths
  localparam int HEAT_W      = 16;
  localparam int COORD_IN_W  = 16;
  localparam int CELL_IN_W   = 6;
  localparam int STRIDE_W    = 5;
  localparam int GRID_W      = 7;
  localparam int SCALE_W     = 20;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = SCALE_W;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 5'd8;
  localparam logic [GRID_W-1:0]   WIDTH_RESET  = 7'd46;
  localparam logic [GRID_W-1:0]   HEIGHT_RESET = 7'd46;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 20'd669;

  localparam logic [HEAT_W-1:0] HEAT_ONE = 16'd32768;

  // Exponent table
  localparam int EXP_ENTRIES = 1024;
  localparam int IDX_W       = $clog2(EXP_ENTRIES);

  localparam longint unsigned LIMIT_Q24    = 64'd77262435;
  localparam longint unsigned LIMIT_DIV    = LIMIT_Q24 + 64'd1;
  localparam longint unsigned LIMIT_Q30    = 64'd4944795848;
  localparam longint unsigned ONE_Q30      = 64'd1 << 30;
  localparam longint unsigned EXP_STEP_Q30 =
    (LIMIT_Q30 + EXP_ENTRIES / 2) / EXP_ENTRIES;

  // Reciprocal for the table index: E * EXP_ENTRIES / LIMIT_DIV
  localparam int LIM_W       = $clog2(LIMIT_DIV);
  localparam int RECIP_SHIFT = 40;
  localparam longint unsigned RECIP = ((64'd1 << RECIP_SHIFT) * EXP_ENTRIES) / LIMIT_DIV;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int QP_W        = LIM_W + RECIP_W;
  localparam int PROD_W      = IDX_W + 1 + LIM_W;

  // Datapath widths
  localparam int MAX_STRIDE  = (1 << STRIDE_W) - 1;
  localparam int POS_W       = $clog2(MAP_SIDE * MAX_STRIDE * 16) + 1;
  localparam int DIFF_W      = ((POS_W > COORD_IN_W) ? POS_W : COORD_IN_W) + 1;
  localparam int SQ_W        = 2 * DIFF_W - 1;
  localparam int D2_W        = SQ_W + 1;
  localparam int E_W         = D2_W + SCALE_W;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SPLAT = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CELL_STRIDE   = 2'd0,
    REG_GRID_WIDTH    = 2'd1,
    REG_GRID_HEIGHT   = 2'd2,
    REG_FALLOFF_SCALE = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic clr_we;
    logic walk_en;
  } ctrl_t;

  typedef logic [HEAT_W-1:0] exp_rom_t [EXP_ENTRIES];

  // exp(-i * 4.6052 / EXP_ENTRIES) in Q1.15, built from a truncated series
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t           rom;
    logic [63:0]        term;
    logic [63:0]        v;
    logic signed [63:0] r;
    term = ONE_Q30;
    r    = signed'(ONE_Q30);
    v    = ONE_Q30;
    term = ((term * EXP_STEP_Q30) >> 30) / 1;  r = r - signed'(term);
    term = ((term * EXP_STEP_Q30) >> 30) / 2;  r = r + signed'(term);
    term = ((term * EXP_STEP_Q30) >> 30) / 3;  r = r - signed'(term);
    term = ((term * EXP_STEP_Q30) >> 30) / 4;  r = r + signed'(term);
    term = ((term * EXP_STEP_Q30) >> 30) / 5;  r = r - signed'(term);
    term = ((term * EXP_STEP_Q30) >> 30) / 6;  r = r + signed'(term);
    term = ((term * EXP_STEP_Q30) >> 30) / 7;  r = r - signed'(term);
    term = ((term * EXP_STEP_Q30) >> 30) / 8;  r = r + signed'(term);
    term = ((term * EXP_STEP_Q30) >> 30) / 9;  r = r - signed'(term);
    term = ((term * EXP_STEP_Q30) >> 30) / 10; r = r + signed'(term);
    if (r < 0) begin
      r = '0;
    end
    for (int k = 0; k < EXP_ENTRIES; k++) begin
      rom[k] = HEAT_W'((v + 64'd16384) >> 15);
      v      = (v * unsigned'(r)) >> 30;
    end
    return rom;
  endfunction

  localparam exp_rom_t EXP_ROM = build_exp_rom();

endpackage

### rtl/ghs_ram.sv
module ghs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/gaussian_heatmap_splat_top.sv
// Channel   | Direction | Handshake                  | Payload
// ----------+-----------+----------------------------+-------------------------------------
// command   | in        | start / busy               | cmd_i, center_x_i, center_y_i,
//           |           |                            | cell_x_i, cell_y_i
// result    | out       | result_valid_o (strobe)    | heat_o
// config    | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Read: result strobed on the next cycle; reads may follow back to back.
// Splat: grid_width x grid_height cells (each clamped to 64), one cell per cycle through
// the heat map RAM read-modify-write loop, then a pipeline drain (skipped cells are not
// written; an empty grid goes straight to the drain).
// Clear: one cell per cycle over all MAP_CELLS (4096) cells. Reset runs the same
// clearing pass with busy high. Results cannot be stalled.
module gaussian_heatmap_splat_top (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              cmd_i,
  input  logic signed [ghs_pkg::COORD_IN_W-1:0]   center_x_i,
  input  logic signed [ghs_pkg::COORD_IN_W-1:0]   center_y_i,
  input  logic [ghs_pkg::CELL_IN_W-1:0]           cell_x_i,
  input  logic [ghs_pkg::CELL_IN_W-1:0]           cell_y_i,
  input  logic                                    cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  logic [ghs_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [ghs_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  output logic                                    result_valid_o,
  output logic [ghs_pkg::HEAT_W-1:0]              heat_o
);

  // Configuration
  logic [ghs_pkg::STRIDE_W-1:0] cell_stride_q;
  logic [ghs_pkg::GRID_W-1:0]   grid_width_q;
  logic [ghs_pkg::GRID_W-1:0]   grid_height_q;
  logic [ghs_pkg::SCALE_W-1:0]  falloff_scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_stride_q   <= ghs_pkg::STRIDE_RESET;
      grid_width_q    <= ghs_pkg::WIDTH_RESET;
      grid_height_q   <= ghs_pkg::HEIGHT_RESET;
      falloff_scale_q <= ghs_pkg::SCALE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (ghs_pkg::cfg_reg_e'(cfg_index_i))
        ghs_pkg::REG_CELL_STRIDE:   cell_stride_q   <= cfg_data_i[ghs_pkg::STRIDE_W-1:0];
        ghs_pkg::REG_GRID_WIDTH:    grid_width_q    <= cfg_data_i[ghs_pkg::GRID_W-1:0];
        ghs_pkg::REG_GRID_HEIGHT:   grid_height_q   <= cfg_data_i[ghs_pkg::GRID_W-1:0];
        ghs_pkg::REG_FALLOFF_SCALE: falloff_scale_q <= cfg_data_i[ghs_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Control
  ghs_pkg::state_e state_q, state_d;
  ghs_pkg::ctrl_t  ctrl;

  logic                          accept;
  logic                          pipe_busy;
  logic                          clr_last;
  logic                          last_x;
  logic                          last_y;
  logic                          grid_empty;
  logic [ghs_pkg::ADDR_W-1:0]    clr_cnt_q;
  logic [ghs_pkg::CNT_W-1:0]     gw_d, gh_d;
  logic [ghs_pkg::CNT_W-1:0]     gw_q, gh_q;
  logic [ghs_pkg::COORD_W-1:0]   gx_q, gy_q;
  logic signed [ghs_pkg::POS_W-1:0]      pos_x_q, pos_y_q;
  logic signed [ghs_pkg::POS_W-1:0]      pos_base, pos_step;
  logic signed [ghs_pkg::COORD_IN_W-1:0] cx_q, cy_q;

  assign busy   = ctrl.busy;
  assign accept = start && !ctrl.busy;

  assign gw_d = (32'(grid_width_q) > ghs_pkg::MAP_SIDE) ?
                ghs_pkg::CNT_W'(ghs_pkg::MAP_SIDE) : ghs_pkg::CNT_W'(grid_width_q);
  assign gh_d = (32'(grid_height_q) > ghs_pkg::MAP_SIDE) ?
                ghs_pkg::CNT_W'(ghs_pkg::MAP_SIDE) : ghs_pkg::CNT_W'(grid_height_q);
  assign grid_empty = (gw_d == '0) || (gh_d == '0);

  assign clr_last = (clr_cnt_q == ghs_pkg::ADDR_W'(ghs_pkg::MAP_CELLS - 1));
  assign last_x   = (ghs_pkg::CNT_W'(gx_q) + ghs_pkg::CNT_W'(1)) == gw_q;
  assign last_y   = (ghs_pkg::CNT_W'(gy_q) + ghs_pkg::CNT_W'(1)) == gh_q;

  // Cell centers in Q.4: stride*8 - 8 for the first, stride*16 apart
  assign pos_base = $signed(ghs_pkg::POS_W'({cell_stride_q, 3'b000})) -
                    $signed(ghs_pkg::POS_W'(8));
  assign pos_step = $signed(ghs_pkg::POS_W'({cell_stride_q, 4'b0000}));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ghs_pkg::ST_CLEAR: begin
        if (clr_last) state_d = ghs_pkg::ST_IDLE;
      end
      ghs_pkg::ST_IDLE: begin
        if (start) begin
          case (ghs_pkg::cmd_e'(cmd_i))
            ghs_pkg::CMD_CLEAR: state_d = ghs_pkg::ST_CLEAR;
            ghs_pkg::CMD_SPLAT: state_d = grid_empty ? ghs_pkg::ST_DRAIN : ghs_pkg::ST_WALK;
            default: ;
          endcase
        end
      end
      ghs_pkg::ST_WALK: begin
        if (last_x && last_y) state_d = ghs_pkg::ST_DRAIN;
      end
      ghs_pkg::ST_DRAIN: begin
        if (!pipe_busy) state_d = ghs_pkg::ST_IDLE;
      end
      default: state_d = ghs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_q)
      ghs_pkg::ST_CLEAR: begin
        ctrl.busy   = 1'b1;
        ctrl.clr_we = 1'b1;
      end
      ghs_pkg::ST_IDLE: ;
      ghs_pkg::ST_WALK: begin
        ctrl.busy    = 1'b1;
        ctrl.walk_en = 1'b1;
      end
      ghs_pkg::ST_DRAIN: begin
        ctrl.busy = 1'b1;
      end
      default: ctrl.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ghs_pkg::ST_CLEAR;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (ctrl.clr_we) begin
        clr_cnt_q <= clr_cnt_q + ghs_pkg::ADDR_W'(1);
      end else if (accept) begin
        clr_cnt_q <= '0;
      end
    end
  end

  // Grid walker
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gx_q <= '0;
      gy_q <= '0;
      gw_q <= '0;
      gh_q <= '0;
    end else if (accept && (ghs_pkg::cmd_e'(cmd_i) == ghs_pkg::CMD_SPLAT)) begin
      gx_q <= '0;
      gy_q <= '0;
      gw_q <= gw_d;
      gh_q <= gh_d;
    end else if (ctrl.walk_en) begin
      if (last_x) begin
        gx_q <= '0;
        gy_q <= gy_q + ghs_pkg::COORD_W'(1);
      end else begin
        gx_q <= gx_q + ghs_pkg::COORD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (ghs_pkg::cmd_e'(cmd_i) == ghs_pkg::CMD_SPLAT)) begin
      pos_x_q <= pos_base;
      pos_y_q <= pos_base;
      cx_q    <= center_x_i;
      cy_q    <= center_y_i;
    end else if (ctrl.walk_en) begin
      if (last_x) begin
        pos_x_q <= pos_base;
        pos_y_q <= pos_y_q + pos_step;
      end else begin
        pos_x_q <= pos_x_q + pos_step;
      end
    end
  end

  // Splat pipeline
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic [ghs_pkg::ADDR_W-1:0] addr1_q, addr2_q, addr3_q, addr4_q, addr5_q, addr6_q, addr7_q;
  logic signed [ghs_pkg::DIFF_W-1:0]   dx1_q, dy1_q;
  logic signed [2*ghs_pkg::DIFF_W-1:0] sqx_full, sqy_full;
  logic [ghs_pkg::SQ_W-1:0]   sqx2_q, sqy2_q;
  logic [ghs_pkg::D2_W-1:0]   d2_3_q;
  logic [ghs_pkg::E_W-1:0]    e4_q;
  logic [ghs_pkg::LIM_W-1:0]  e_low;
  logic [ghs_pkg::QP_W-1:0]   qprod;
  logic                       skip5_q, skip6_q;
  logic [ghs_pkg::IDX_W-1:0]  q5_q, q6_q;
  logic [ghs_pkg::LIM_W-1:0]  el5_q;
  logic [ghs_pkg::PROD_W-1:0] prod6_q, ee6_q;
  logic [ghs_pkg::IDX_W-1:0]  rom_idx;
  logic [ghs_pkg::HEAT_W-1:0] rom_q;

  assign pipe_busy = v1_q | v2_q | v3_q | v4_q | v5_q | v6_q | v7_q;

  assign sqx_full = dx1_q * dx1_q;
  assign sqy_full = dy1_q * dy1_q;
  assign e_low    = e4_q[ghs_pkg::LIM_W-1:0];
  assign qprod    = ghs_pkg::QP_W'(e_low) * ghs_pkg::QP_W'(ghs_pkg::RECIP);
  // The reciprocal estimate is low by at most one: bump it when the next step fits
  assign rom_idx  = q6_q + ghs_pkg::IDX_W'(prod6_q <= ee6_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= ctrl.walk_en;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q && !skip6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    addr1_q <= {gy_q, gx_q};
    dx1_q   <= ghs_pkg::DIFF_W'(pos_x_q) - ghs_pkg::DIFF_W'(cx_q);
    dy1_q   <= ghs_pkg::DIFF_W'(pos_y_q) - ghs_pkg::DIFF_W'(cy_q);

    addr2_q <= addr1_q;
    sqx2_q  <= sqx_full[ghs_pkg::SQ_W-1:0];
    sqy2_q  <= sqy_full[ghs_pkg::SQ_W-1:0];

    addr3_q <= addr2_q;
    d2_3_q  <= ghs_pkg::D2_W'(sqx2_q) + ghs_pkg::D2_W'(sqy2_q);

    addr4_q <= addr3_q;
    e4_q    <= ghs_pkg::E_W'(d2_3_q) * ghs_pkg::E_W'(falloff_scale_q);

    addr5_q <= addr4_q;
    skip5_q <= e4_q > ghs_pkg::E_W'(ghs_pkg::LIMIT_Q24);
    el5_q   <= e_low;
    q5_q    <= qprod[ghs_pkg::RECIP_SHIFT +: ghs_pkg::IDX_W];

    addr6_q <= addr5_q;
    skip6_q <= skip5_q;
    q6_q    <= q5_q;
    prod6_q <= (ghs_pkg::PROD_W'(q5_q) + ghs_pkg::PROD_W'(1)) *
               ghs_pkg::PROD_W'(ghs_pkg::LIMIT_DIV);
    ee6_q   <= ghs_pkg::PROD_W'(el5_q) * ghs_pkg::PROD_W'(ghs_pkg::EXP_ENTRIES);

    addr7_q <= addr6_q;
    rom_q   <= ghs_pkg::EXP_ROM[rom_idx];
  end

  // Heat map RAM: read in stage 6, add and write back in stage 7
  logic                       ram_we;
  logic [ghs_pkg::ADDR_W-1:0] ram_waddr;
  logic [ghs_pkg::HEAT_W-1:0] ram_wdata;
  logic [ghs_pkg::ADDR_W-1:0] ram_raddr;
  logic [ghs_pkg::HEAT_W-1:0] ram_rdata;
  logic [ghs_pkg::HEAT_W:0]   heat_sum;
  logic [ghs_pkg::HEAT_W-1:0] heat_sat;

  assign heat_sum = {1'b0, ram_rdata} + {1'b0, rom_q};
  assign heat_sat = (heat_sum > {1'b0, ghs_pkg::HEAT_ONE}) ?
                    ghs_pkg::HEAT_ONE : heat_sum[ghs_pkg::HEAT_W-1:0];

  assign ram_we    = ctrl.clr_we || v7_q;
  assign ram_waddr = ctrl.clr_we ? clr_cnt_q : addr7_q;
  assign ram_wdata = ctrl.clr_we ? '0 : heat_sat;
  assign ram_raddr = ctrl.busy ? addr6_q :
                     {ghs_pkg::COORD_W'(cell_y_i), ghs_pkg::COORD_W'(cell_x_i)};

  ghs_ram #(
    .WIDTH(ghs_pkg::HEAT_W),
    .DEPTH(ghs_pkg::MAP_CELLS)
  ) u_heat_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Read results
  logic rd_pending_q;
  logic in_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pending_q <= 1'b0;
      in_map_q     <= 1'b0;
    end else begin
      rd_pending_q <= accept && (ghs_pkg::cmd_e'(cmd_i) == ghs_pkg::CMD_READ);
      in_map_q     <= (32'(cell_x_i) < ghs_pkg::MAP_SIDE) &&
                      (32'(cell_y_i) < ghs_pkg::MAP_SIDE);
    end
  end

  assign result_valid_o = rd_pending_q;
  assign heat_o         = (rd_pending_q && in_map_q) ? ram_rdata : '0;

  // Checks
  a_no_write_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.clr_we && v7_q))
    else $error("clear sweep and splat write-back collide");

  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy && (cmd_i == ghs_pkg::CMD_READ)))
    else $error("result without a read request");

  a_heat_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_wdata <= ghs_pkg::HEAT_ONE))
    else $error("heat written above 1.0");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ghs_pkg::ST_IDLE) |-> !pipe_busy)
    else $error("splat pipeline busy while idle");

endmodule

### test/ghs_heat_checker.sv
`timescale 1ns / 1ps
module ghs_heat_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  busy_i,
  input  logic [1:0]                            cmd_i,
  input  logic signed [ghs_pkg::COORD_IN_W-1:0] center_x_i,
  input  logic signed [ghs_pkg::COORD_IN_W-1:0] center_y_i,
  input  logic [ghs_pkg::CELL_IN_W-1:0]         cell_x_i,
  input  logic [ghs_pkg::CELL_IN_W-1:0]         cell_y_i,
  input  logic                                  cfg_valid_i,
  input  logic                                  cfg_ready_i,
  input  logic [ghs_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [ghs_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  result_valid_i,
  input  logic [ghs_pkg::HEAT_W-1:0]            heat_i,
  output int                                    fail_count_o,
  output int                                    pending_o
);

  localparam int              TABLE_SIZE = 1024;
  localparam int              SIDE       = 64;
  localparam longint unsigned SKIP_ABOVE = 64'd77262435;
  localparam longint unsigned SPAN_Q30   = 64'd4944795848;
  localparam longint unsigned UNIT_Q30   = 64'd1 << 30;
  localparam longint unsigned HEAT_FULL  = 64'd32768;

  logic [ghs_pkg::HEAT_W-1:0]   falloff_rom [TABLE_SIZE];
  logic [ghs_pkg::HEAT_W-1:0]   heat_map [SIDE*SIDE];
  logic [ghs_pkg::HEAT_W-1:0]   heat_expected [$];
  logic [ghs_pkg::HEAT_W-1:0]   heat_want;
  logic [ghs_pkg::STRIDE_W-1:0] stride_q;
  logic [ghs_pkg::GRID_W-1:0]   width_q;
  logic [ghs_pkg::GRID_W-1:0]   height_q;
  logic [ghs_pkg::SCALE_W-1:0]  falloff_q;

  // exp(-i * 4.6052 / TABLE_SIZE): repeated products of a truncated series step
  initial begin
    longint unsigned step;
    longint unsigned term;
    longint unsigned v;
    longint          ratio;
    step  = (SPAN_Q30 + TABLE_SIZE / 2) / TABLE_SIZE;
    term  = UNIT_Q30;
    ratio = longint'(UNIT_Q30);
    v     = UNIT_Q30;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * step) >> 30) / longint'(k);
      if (k % 2 == 1) begin
        ratio = ratio - longint'(term);
      end else begin
        ratio = ratio + longint'(term);
      end
    end
    if (ratio < 0) begin
      ratio = 0;
    end
    for (int k = 0; k < TABLE_SIZE; k++) begin
      falloff_rom[k] = ghs_pkg::HEAT_W'((v + 64'd16384) >> 15);
      v = (v * $unsigned(ratio)) >> 30;
    end
  end

  function automatic void clear_map();
    for (int a = 0; a < SIDE * SIDE; a++) begin
      heat_map[a] = '0;
    end
  endfunction

  function automatic void splat_keypoint(input longint cx, input longint cy);
    longint          gw;
    longint          gh;
    longint          s;
    longint          base;
    longint          dx;
    longint          dy;
    longint unsigned d2;
    longint unsigned e;
    longint unsigned idx;
    longint unsigned sum;
    gw   = (width_q > SIDE) ? SIDE : longint'(width_q);
    gh   = (height_q > SIDE) ? SIDE : longint'(height_q);
    s    = longint'(stride_q);
    base = s * 8 - 8;
    for (longint gy = 0; gy < gh; gy++) begin
      dy = base + gy * s * 16 - cy;
      for (longint gx = 0; gx < gw; gx++) begin
        dx = base + gx * s * 16 - cx;
        d2 = $unsigned(dx * dx) + $unsigned(dy * dy);
        e  = d2 * longint'(falloff_q);
        // skip cells past the cutoff exponent
        if (e <= SKIP_ABOVE) begin
          idx = (e * TABLE_SIZE) / (SKIP_ABOVE + 1);
          sum = longint'(heat_map[gy*SIDE+gx]) + longint'(falloff_rom[idx]);
          heat_map[gy*SIDE+gx] = (sum > HEAT_FULL) ? ghs_pkg::HEAT_W'(HEAT_FULL)
                                                   : ghs_pkg::HEAT_W'(sum);
        end
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_map();
      stride_q  = ghs_pkg::STRIDE_RESET;
      width_q   = ghs_pkg::WIDTH_RESET;
      height_q  = ghs_pkg::HEIGHT_RESET;
      falloff_q = ghs_pkg::SCALE_RESET;
      heat_expected.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // check the result first: it belongs to a request accepted earlier
      if (result_valid_i) begin
        if (heat_expected.size() == 0) begin
          $error("heat: expected none, actual %0d", heat_i);
          fail_count_o++;
        end else begin
          heat_want = heat_expected.pop_front();
          if (heat_i !== heat_want) begin
            $error("heat: expected %0d, actual %0d", heat_want, heat_i);
            fail_count_o++;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (ghs_pkg::cfg_reg_e'(cfg_index_i))
          ghs_pkg::REG_CELL_STRIDE:   stride_q  = cfg_data_i[ghs_pkg::STRIDE_W-1:0];
          ghs_pkg::REG_GRID_WIDTH:    width_q   = cfg_data_i[ghs_pkg::GRID_W-1:0];
          ghs_pkg::REG_GRID_HEIGHT:   height_q  = cfg_data_i[ghs_pkg::GRID_W-1:0];
          ghs_pkg::REG_FALLOFF_SCALE: falloff_q = cfg_data_i[ghs_pkg::SCALE_W-1:0];
          default: ;
        endcase
      end
      if (start_i && !busy_i) begin
        case (cmd_i)
          ghs_pkg::CMD_CLEAR: clear_map();
          ghs_pkg::CMD_SPLAT: splat_keypoint(center_x_i, center_y_i);
          ghs_pkg::CMD_READ:  heat_expected = {heat_expected, heat_map[cell_y_i*SIDE+cell_x_i]};
          default: ;
        endcase
      end
      pending_o = heat_expected.size();
    end
  end

endmodule

### test/tb_gaussian_heatmap_splat_top.sv
`timescale 1ns / 1ps
module tb_gaussian_heatmap_splat_top;

  localparam int          IDLE_LIMIT      = 20000;
  localparam int          SETTLE_CYCLES   = 16;
  localparam int          RANDOM_PHASES   = 7;
  localparam int          ITEMS_PER_PHASE = 16;
  localparam logic [1:0]  CMD_UNUSED      = 2'd3;

  logic                                   clk;
  logic                                   rst_n;
  logic                                   start;
  logic                                   busy;
  logic [1:0]                             cmd;
  logic signed [ghs_pkg::COORD_IN_W-1:0]  center_x;
  logic signed [ghs_pkg::COORD_IN_W-1:0]  center_y;
  logic [ghs_pkg::CELL_IN_W-1:0]          cell_x;
  logic [ghs_pkg::CELL_IN_W-1:0]          cell_y;
  logic                                   cfg_valid;
  logic                                   cfg_ready;
  logic [ghs_pkg::CFG_IDX_W-1:0]          cfg_index;
  logic [ghs_pkg::CFG_DATA_W-1:0]         cfg_data;
  logic                                   result_valid;
  logic [ghs_pkg::HEAT_W-1:0]             heat;
  int                                     fail_count;
  int                                     pending;
  int                                     idle_cycles = 0;
  bit                                     no_gaps = 1'b0;

  gaussian_heatmap_splat_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .cell_x_i       (cell_x),
    .cell_y_i       (cell_y),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .result_valid_o (result_valid),
    .heat_o         (heat)
  );

  ghs_heat_checker u_heat_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .cmd_i          (cmd),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .cell_x_i       (cell_x),
    .cell_y_i       (cell_y),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .result_valid_i (result_valid),
    .heat_i         (heat),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || (cfg_valid && cfg_ready) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 40) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ghs_pkg::GRID_W-1:0] pick_extent();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return ghs_pkg::GRID_W'($urandom_range(1, 12));
    if (roll < 90) return ghs_pkg::GRID_W'($urandom_range(13, 64));
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return ghs_pkg::GRID_W'(64);
      default: return ghs_pkg::GRID_W'($urandom_range(65, 127));
    endcase
  endfunction

  task automatic issue_request(input logic [1:0] op, input logic [15:0] cx, input logic [15:0] cy,
                               input logic [5:0] px, input logic [5:0] py);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    cmd      <= op;
    center_x <= cx;
    center_y <= cy;
    cell_x   <= px;
    cell_y   <= py;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drop start, wait for all reads to return and the block to go quiet
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    @(negedge clk);
    while (busy || pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input ghs_pkg::cfg_reg_e idx,
                           input logic [ghs_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [ghs_pkg::STRIDE_W-1:0] s,
                           input logic [ghs_pkg::GRID_W-1:0] w,
                           input logic [ghs_pkg::GRID_W-1:0] h,
                           input logic [ghs_pkg::SCALE_W-1:0] f);
    wait_idle();
    write_reg(ghs_pkg::REG_CELL_STRIDE, ghs_pkg::CFG_DATA_W'(s));
    write_reg(ghs_pkg::REG_GRID_WIDTH, ghs_pkg::CFG_DATA_W'(w));
    write_reg(ghs_pkg::REG_GRID_HEIGHT, ghs_pkg::CFG_DATA_W'(h));
    write_reg(ghs_pkg::REG_FALLOFF_SCALE, ghs_pkg::CFG_DATA_W'(f));
  endtask

  task automatic run_phase();
    int                           counted;
    int                           roll;
    int                           sig;
    int                           gw;
    int                           gh;
    int                           span_x;
    int                           span_y;
    logic [ghs_pkg::STRIDE_W-1:0] s;
    logic [ghs_pkg::GRID_W-1:0]   w;
    logic [ghs_pkg::GRID_W-1:0]   h;
    logic [ghs_pkg::SCALE_W-1:0]  f;
    logic [15:0]                  cx;
    logic [15:0]                  cy;
    logic [5:0]                   px;
    logic [5:0]                   py;
    s = ($urandom_range(0, 99) < 75) ? ghs_pkg::STRIDE_W'($urandom_range(1, 16))
                                     : ghs_pkg::STRIDE_W'($urandom_range(0, 31));
    w = pick_extent();
    h = pick_extent();
    if ($urandom_range(0, 99) < 85) begin
      // sigma of a half to three strides keeps the spot visible on the grid
      sig = ((s == 0) ? 1 : int'(s)) * $urandom_range(1, 6) / 2;
      if (sig < 1) sig = 1;
      f = ghs_pkg::SCALE_W'(65536 / (2 * sig * sig));
      if (f == 0) f = 1;
    end else begin
      case ($urandom_range(0, 3))
        0:       f = '0;
        1:       f = ghs_pkg::SCALE_W'(1);
        2:       f = '1;
        default: f = ghs_pkg::SCALE_W'($urandom);
      endcase
    end
    configure(s, w, h, f);
    gw = (w > 64) ? 64 : int'(w);
    gh = (h > 64) ? 64 : int'(h);
    span_x = int'(s) * 16 * ((gw == 0) ? 1 : gw) + 64;
    span_y = int'(s) * 16 * ((gh == 0) ? 1 : gh) + 64;
    counted = 0;
    while (counted < ITEMS_PER_PHASE) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        issue_request(CMD_UNUSED, 16'($urandom), 16'($urandom), 6'($urandom), 6'($urandom));
      end else begin
        counted++;
        if (roll < 11) begin
          issue_request(ghs_pkg::CMD_CLEAR, 16'($urandom), 16'($urandom),
                        6'($urandom), 6'($urandom));
        end else if (roll < 45) begin
          if ($urandom_range(0, 99) < 85) begin
            cx = 16'($urandom_range(0, span_x) - 32);
            cy = 16'($urandom_range(0, span_y) - 32);
          end else begin
            cx = 16'($urandom);
            cy = 16'($urandom);
          end
          issue_request(ghs_pkg::CMD_SPLAT, cx, cy, 6'($urandom), 6'($urandom));
        end else begin
          if ($urandom_range(0, 99) < 80) begin
            px = 6'($urandom_range(0, (gw > 0) ? gw - 1 : 0));
            py = 6'($urandom_range(0, (gh > 0) ? gh - 1 : 0));
          end else begin
            px = 6'($urandom);
            py = 6'($urandom);
          end
          issue_request(ghs_pkg::CMD_READ, 16'($urandom), 16'($urandom), px, py);
        end
      end
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    cmd       = ghs_pkg::CMD_CLEAR;
    center_x  = '0;
    center_y  = '0;
    cell_x    = '0;
    cell_y    = '0;
    cfg_valid = 1'b0;
    cfg_index = ghs_pkg::REG_CELL_STRIDE;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: stride 8, 46 x 46 grid, first center at 3.5 px
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_SPLAT, 16'd696, 16'd696, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd5, 6'd5);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd6, 6'd5);
    issue_request(ghs_pkg::CMD_SPLAT, 16'd700, 16'd690, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd5, 6'd5);
    issue_request(ghs_pkg::CMD_SPLAT, 16'h8000, 16'h8000, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_SPLAT, 16'h7FFF, 16'h7FFF, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_SPLAT, 16'hFFF0, 16'hFFF0, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd63, 6'd63);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd45, 6'd45);
    issue_request(CMD_UNUSED, 16'hFFFF, 16'h5A5A, 6'h3F, 6'h2A);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd5, 6'd5);
    issue_request(ghs_pkg::CMD_CLEAR, 16'd0, 16'd0, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd5, 6'd5);

    // zero falloff: every visited cell takes a full 1.0
    configure(5'd31, 7'd64, 7'd64, '0);
    issue_request(ghs_pkg::CMD_SPLAT, 16'h1234, 16'hEDCB, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd63, 6'd63);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd0, 6'd0);

    // zero stride puts every center at -0.5 px; oversized width clamps
    configure(5'd0, 7'd127, 7'd2, 20'hFFFFF);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd40, 6'd40);
    issue_request(ghs_pkg::CMD_SPLAT, 16'hFFF8, 16'hFFF8, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd63, 6'd1);

    // empty grid: a splat touches nothing
    configure(5'd5, 7'd0, 7'd9, 20'd669);
    issue_request(ghs_pkg::CMD_CLEAR, 16'd0, 16'd0, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_SPLAT, 16'd40, 16'd40, 6'd0, 6'd0);
    issue_request(ghs_pkg::CMD_READ, 16'd0, 16'd0, 6'd0, 6'd0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      no_gaps = (phase % 3 == 1);
      run_phase();
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### gaussian_heatmap_splat_top.f
rtl/ghs_pkg.sv
rtl/ghs_ram.sv
rtl/gaussian_heatmap_splat_top.sv
test/ghs_heat_checker.sv
test/tb_gaussian_heatmap_splat_top.sv
